### hdl/rtma_pkg.sv
// rtma_pkg: shared types and constants for the radar triggered motor actuator
// no dependencies; used by the top level
`default_nettype none

package rtma_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_FWD       = 3'd1,
    PH_BACK      = 3'd2,
    PH_BRAKE     = 3'd3,
    PH_FLASH_ON  = 3'd4,
    PH_FLASH_OFF = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CFG_OPEN_TIME     = 3'd0,
    CFG_CLOSE_TIME    = 3'd1,
    CFG_BRAKE_TIME    = 3'd2,
    CFG_FLASH_HALF    = 3'd3,
    CFG_FLASH_REPEATS = 3'd4,
    CFG_POLL_PERIOD   = 3'd5,
    CFG_START_OPEN    = 3'd6,
    CFG_START_RADAR   = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] MOTOR_STOP  = 2'd0;
  localparam logic [1:0] MOTOR_FWD   = 2'd1;
  localparam logic [1:0] MOTOR_BACK  = 2'd2;
  localparam logic [1:0] MOTOR_BRAKE = 2'd3;

  localparam int PEND_RADAR  = 0;
  localparam int PEND_FLASH  = 1;
  localparam int PEND_BUTTON = 2;

  localparam logic [15:0] RST_OPEN_TIME     = 16'd1000;
  localparam logic [15:0] RST_CLOSE_TIME    = 16'd600;
  localparam logic [15:0] RST_BRAKE_TIME    = 16'd100;
  localparam logic [15:0] RST_FLASH_HALF    = 16'd100;
  localparam logic [3:0]  RST_FLASH_REPEATS = 4'd3;
  localparam logic [7:0]  RST_POLL_PERIOD   = 8'd10;
  localparam logic        RST_START_OPEN    = 1'b0;
  localparam logic        RST_START_RADAR   = 1'b1;

  typedef struct packed {
    logic [15:0] open_time;
    logic [15:0] close_time;
    logic [15:0] brake_time;
    logic [15:0] flash_half;
    logic [3:0]  flash_repeats;
    logic [7:0]  poll_period;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  pending;
    logic [7:0]  poll_timer;
    logic [3:0]  flash_count;
    logic        open_flag;
    logic        radar_flag;
    logic        b1_armed;
    logic        b2_armed;
    logic        strobe;
  } seq_t;

endpackage

`default_nettype wire

### hdl/rtma_in_if.sv
// rtma_in_if: tick input channel, one word per millisecond tick
// depends on nothing
`default_nettype none

interface rtma_in_if;
  logic valid;
  logic ready;
  logic button_one_level;
  logic button_two_level;
  logic radar_level;

  modport source (output valid, output button_one_level, output button_two_level,
                  output radar_level, input ready);
  modport sink (input valid, input button_one_level, input button_two_level,
                input radar_level, output ready);
endinterface

`default_nettype wire

### hdl/rtma_out_if.sv
// rtma_out_if: result channel, one word per accepted tick
// depends on nothing
`default_nettype none

interface rtma_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_drive;
  logic       led_on;
  logic       is_open;
  logic       radar_enabled;
  logic       save_strobe;
  logic       busy_res;

  modport source (output valid, output motor_drive, output led_on, output is_open,
                  output radar_enabled, output save_strobe, output busy_res,
                  input ready);
  modport sink (input valid, input motor_drive, input led_on, input is_open,
                input radar_enabled, input save_strobe, input busy_res,
                output ready);
endinterface

`default_nettype wire

### hdl/rtma_cfg_if.sv
// rtma_cfg_if: configuration write channel, register index and write data
// depends on nothing
`default_nettype none

interface rtma_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/radar_triggered_motor_actuator_top.sv
// radar_triggered_motor_actuator_top: tick driven motor and led sequencer
// depends on rtma_pkg, rtma_in_if, rtma_out_if, rtma_cfg_if
//
// usage
//   in_ch carries one word per millisecond tick: both button levels and the
//   radar level. every accepted word yields exactly one word on out_ch with
//   motor drive code, led level, open and radar flags, save strobe and busy.
//   cfg_ch writes timing registers by index; it is always ready and a write
//   takes effect on the next tick. start_open and start_radar_on only take
//   part at reset, where their reset values load the open and radar flags.
//   a word accepted on in_ch passes the input register, then the state
//   update into the result register, before it is presented on out_ch.
//   throughput: one word per cycle while out_ch is taken; the sequencer
//   state is updated in one pass per tick, skipping zero length phases.
//   stall: when out_ch is not taken, the result register holds and the
//   input register fills, after which in_ch.ready drops until out_ch moves.
//   reset: synchronous, active low; clears both valid flags, sets the phase
//   to idle, loads the configuration reset values.
`default_nettype none

module radar_triggered_motor_actuator_top #(
  parameter int TIMER_BITS = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  rtma_in_if.sink        in_ch,
  rtma_out_if.source     out_ch,
  rtma_cfg_if.sink       cfg_ch
);

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  typedef struct packed {
    rtma_pkg::seq_t          s;
    logic [TIMER_BITS-1:0]   timer;
  } ctx_t;

  rtma_pkg::cfg_t          cfg_r;
  rtma_pkg::seq_t          seq_r;
  logic [TIMER_BITS-1:0]   timer_r;

  logic                    in_v_r;
  logic                    b1_r;
  logic                    b2_r;
  logic                    radar_r;

  logic                    out_v_r;
  logic [1:0]              motor_r;
  logic                    led_r;
  logic                    open_r;
  logic                    radar_en_r;
  logic                    strobe_r;
  logic                    busy_r;

  logic                    out_free;
  logic                    adv;

  ctx_t                    ctx_cur;
  ctx_t                    ctx_end;
  ctx_t                    ctx_poll;
  ctx_t                    ctx_nxt;
  logic [7:0]              poll_inc;
  logic [TIMER_BITS-1:0]   timer_nxt;
  logic [1:0]              motor_nxt;
  logic                    led_nxt;

  function automatic logic [TIMER_BITS-1:0] clip(input logic [15:0] t);
    logic [31:0] t32;
    t32 = {16'd0, t};
    if (t32 > TIMER_MAX) begin
      clip = TIMER_MAX[TIMER_BITS-1:0];
    end else begin
      clip = t32[TIMER_BITS-1:0];
    end
  endfunction

  // start queued actions in order until one has a phase with time left
  function automatic ctx_t start_chain(input ctx_t c, input rtma_pkg::cfg_t g);
    ctx_t        r;
    logic        fwd;
    logic [15:0] drive;
    r = c;
    for (int i = 0; i < 3; i++) begin
      if (r.s.phase == rtma_pkg::PH_IDLE && r.s.pending != 3'd0) begin
        if (r.s.pending[rtma_pkg::PEND_RADAR] || !r.s.pending[rtma_pkg::PEND_FLASH]) begin
          if (!r.s.pending[rtma_pkg::PEND_RADAR]) begin
            r.s.open_flag = ~r.s.open_flag;
            r.s.strobe    = 1'b1;
          end
          fwd   = r.s.pending[rtma_pkg::PEND_RADAR] ? ~r.s.open_flag : r.s.open_flag;
          drive = fwd ? g.open_time : g.close_time;
          if (drive != 16'd0) begin
            r.s.phase = fwd ? rtma_pkg::PH_FWD : rtma_pkg::PH_BACK;
            r.timer   = clip(drive);
          end else if (g.brake_time != 16'd0) begin
            r.s.phase = rtma_pkg::PH_BRAKE;
            r.timer   = clip(g.brake_time);
          end else if (r.s.pending[rtma_pkg::PEND_RADAR]) begin
            r.s.open_flag                       = ~r.s.open_flag;
            r.s.strobe                          = 1'b1;
            r.s.pending[rtma_pkg::PEND_RADAR]   = 1'b0;
          end else begin
            r.s.pending[rtma_pkg::PEND_BUTTON]  = 1'b0;
          end
        end else begin
          r.s.radar_flag  = ~r.s.radar_flag;
          r.s.strobe      = 1'b1;
          r.s.flash_count = 4'd0;
          if (g.flash_half != 16'd0) begin
            r.s.phase = rtma_pkg::PH_FLASH_ON;
            r.timer   = clip(g.flash_half);
          end else begin
            r.s.pending[rtma_pkg::PEND_FLASH] = 1'b0;
          end
        end
      end
    end
    start_chain = r;
  endfunction

  // close the phase whose time ran out, skipping zero length phases
  function automatic ctx_t end_phase(input ctx_t c, input rtma_pkg::cfg_t g);
    ctx_t       r;
    logic [3:0] cnt;
    logic       fin_m;
    logic       fin_f;
    r     = c;
    cnt   = c.s.flash_count + 4'd1;
    fin_m = 1'b0;
    fin_f = 1'b0;
    unique case (c.s.phase) inside
      rtma_pkg::PH_FWD, rtma_pkg::PH_BACK: begin
        if (g.brake_time != 16'd0) begin
          r.s.phase = rtma_pkg::PH_BRAKE;
          r.timer   = clip(g.brake_time);
        end else begin
          fin_m = 1'b1;
        end
      end
      rtma_pkg::PH_BRAKE: begin
        fin_m = 1'b1;
      end
      rtma_pkg::PH_FLASH_ON: begin
        if (g.flash_half != 16'd0) begin
          r.s.phase = rtma_pkg::PH_FLASH_OFF;
          r.timer   = clip(g.flash_half);
        end else begin
          fin_f = 1'b1;
        end
      end
      rtma_pkg::PH_FLASH_OFF: begin
        r.s.flash_count = cnt;
        if (cnt >= g.flash_repeats || cnt == 4'd0 || g.flash_half == 16'd0) begin
          fin_f = 1'b1;
        end else begin
          r.s.phase = rtma_pkg::PH_FLASH_ON;
          r.timer   = clip(g.flash_half);
        end
      end
      default: begin
        r.s.phase = rtma_pkg::PH_IDLE;
        r.timer   = '0;
      end
    endcase
    if (fin_m) begin
      if (r.s.pending[rtma_pkg::PEND_RADAR]) begin
        r.s.open_flag                     = ~r.s.open_flag;
        r.s.strobe                        = 1'b1;
        r.s.pending[rtma_pkg::PEND_RADAR] = 1'b0;
      end else begin
        r.s.pending[rtma_pkg::PEND_BUTTON] = 1'b0;
      end
    end
    if (fin_f) begin
      r.s.pending[rtma_pkg::PEND_FLASH] = 1'b0;
    end
    if (fin_m || fin_f) begin
      r.s.phase = rtma_pkg::PH_IDLE;
      r.timer   = '0;
    end
    end_phase = r;
  endfunction

  // handshake
  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;
  assign cfg_ch.ready = 1'b1;

  // next state for one tick
  always_comb begin
    ctx_cur          = '{s: seq_r, timer: timer_r};
    ctx_cur.s.strobe = 1'b0;
    if (ctx_cur.s.phase != rtma_pkg::PH_IDLE && ctx_cur.timer == '0) begin
      ctx_end = start_chain(end_phase(ctx_cur, cfg_r), cfg_r);
    end else begin
      ctx_end = ctx_cur;
    end
    ctx_poll = ctx_end;
    poll_inc = ctx_end.s.poll_timer + 8'd1;
    if (ctx_end.s.phase == rtma_pkg::PH_IDLE && ctx_end.s.pending == 3'd0) begin
      ctx_poll.s.poll_timer = poll_inc;
      if (poll_inc >= cfg_r.poll_period) begin
        ctx_poll.s.poll_timer = 8'd0;
        if (ctx_end.s.radar_flag && (radar_r != ctx_end.s.open_flag)) begin
          ctx_poll.s.pending[rtma_pkg::PEND_RADAR] = 1'b1;
        end
        if (!b2_r) begin
          ctx_poll.s.b2_armed = 1'b1;
        end else if (ctx_end.s.b2_armed) begin
          ctx_poll.s.b2_armed                      = 1'b0;
          ctx_poll.s.pending[rtma_pkg::PEND_FLASH] = 1'b1;
        end
        if (!b1_r) begin
          ctx_poll.s.b1_armed = 1'b1;
        end else if (ctx_end.s.b1_armed) begin
          ctx_poll.s.b1_armed                       = 1'b0;
          ctx_poll.s.pending[rtma_pkg::PEND_BUTTON] = 1'b1;
        end
      end
    end
    ctx_nxt = start_chain(ctx_poll, cfg_r);
    if (ctx_nxt.s.phase != rtma_pkg::PH_IDLE && ctx_nxt.timer != '0) begin
      timer_nxt = ctx_nxt.timer - 1'b1;
    end else begin
      timer_nxt = ctx_nxt.timer;
    end
  end

  // outputs of the phase active on this tick
  always_comb begin
    motor_nxt = rtma_pkg::MOTOR_STOP;
    led_nxt   = 1'b0;
    unique case (ctx_nxt.s.phase)
      rtma_pkg::PH_FWD:       motor_nxt = rtma_pkg::MOTOR_FWD;
      rtma_pkg::PH_BACK:      motor_nxt = rtma_pkg::MOTOR_BACK;
      rtma_pkg::PH_BRAKE:     motor_nxt = rtma_pkg::MOTOR_BRAKE;
      rtma_pkg::PH_FLASH_ON:  led_nxt   = 1'b1;
      rtma_pkg::PH_FLASH_OFF: led_nxt   = ctx_nxt.s.radar_flag;
      default: begin
        motor_nxt = rtma_pkg::MOTOR_STOP;
        led_nxt   = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_time     <= rtma_pkg::RST_OPEN_TIME;
      cfg_r.close_time    <= rtma_pkg::RST_CLOSE_TIME;
      cfg_r.brake_time    <= rtma_pkg::RST_BRAKE_TIME;
      cfg_r.flash_half    <= rtma_pkg::RST_FLASH_HALF;
      cfg_r.flash_repeats <= rtma_pkg::RST_FLASH_REPEATS;
      cfg_r.poll_period   <= rtma_pkg::RST_POLL_PERIOD;
    end else if (cfg_ch.valid) begin
      unique case (rtma_pkg::cfg_idx_t'(cfg_ch.index))
        rtma_pkg::CFG_OPEN_TIME:     cfg_r.open_time     <= cfg_ch.data;
        rtma_pkg::CFG_CLOSE_TIME:    cfg_r.close_time    <= cfg_ch.data;
        rtma_pkg::CFG_BRAKE_TIME:    cfg_r.brake_time    <= cfg_ch.data;
        rtma_pkg::CFG_FLASH_HALF:    cfg_r.flash_half    <= cfg_ch.data;
        rtma_pkg::CFG_FLASH_REPEATS: cfg_r.flash_repeats <= cfg_ch.data[3:0];
        rtma_pkg::CFG_POLL_PERIOD:   cfg_r.poll_period   <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      b1_r    <= in_ch.button_one_level;
      b2_r    <= in_ch.button_two_level;
      radar_r <= in_ch.radar_level;
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase       <= rtma_pkg::PH_IDLE;
      seq_r.pending     <= 3'd0;
      seq_r.poll_timer  <= 8'd0;
      seq_r.flash_count <= 4'd0;
      seq_r.open_flag   <= rtma_pkg::RST_START_OPEN;
      seq_r.radar_flag  <= rtma_pkg::RST_START_RADAR;
      seq_r.b1_armed    <= 1'b0;
      seq_r.b2_armed    <= 1'b0;
      seq_r.strobe      <= 1'b0;
      timer_r           <= '0;
      out_v_r           <= 1'b0;
    end else if (adv) begin
      seq_r   <= ctx_nxt.s;
      timer_r <= timer_nxt;
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (adv) begin
      motor_r    <= motor_nxt;
      led_r      <= led_nxt;
      open_r     <= ctx_nxt.s.open_flag;
      radar_en_r <= ctx_nxt.s.radar_flag;
      strobe_r   <= ctx_nxt.s.strobe;
      busy_r     <= (ctx_nxt.s.phase != rtma_pkg::PH_IDLE);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.motor_drive   = motor_r;
  assign out_ch.led_on        = led_r;
  assign out_ch.is_open       = open_r;
  assign out_ch.radar_enabled = radar_en_r;
  assign out_ch.save_strobe   = strobe_r;
  assign out_ch.busy_res      = busy_r;

`ifndef SYNTH
  // idle sequencer never leaves work queued
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.phase == rtma_pkg::PH_IDLE |-> seq_r.pending == 3'd0)
    else $error("idle phase with queued actions");

  // a running motor or led pattern always reports busy
  a_motor_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (motor_r != rtma_pkg::MOTOR_STOP || led_r) |-> busy_r)
    else $error("motor or led active while not busy");

  // led and motor never active together
  a_led_motor_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && led_r |-> motor_r == rtma_pkg::MOTOR_STOP)
    else $error("led on during motor phase");

  // a word taken from the input register always lands in the result register
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("tick lost between stages");

  // input side only stalls with a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_v_r && out_v_r)
    else $error("input stalled with free stage");
`endif

endmodule

`default_nettype wire
